// ===== design/pfcm_pkg.sv =====
// Package for the PFC current reference multiplier core.
// Holds the shared types, state and command codes and constants.
// No dependencies; every other design file imports it.
package pfcm_pkg;

  localparam int ProdShift = 13;
  localparam int RefShift  = 15;
  localparam int DivSteps  = 32;
  localparam int CountW    = $clog2(DivSteps);

  localparam logic [15:0] DacLimitReset    = 16'd4095;
  localparam logic [18:0] SquareFloorReset = 19'd1;

  typedef enum logic [1:0] {
    CFG_RUN_ENABLE,
    CFG_DAC_LIMIT,
    CFG_SQUARE_FLOOR,
    CFG_INV_NUMERATOR
  } cfg_index_t;

  typedef enum logic [1:0] {
    MUL_CUR_ERR,
    MUL_SCALED_INV,
    MUL_VOLT_SQ
  } mul_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_SAT,
    S_SQUARE,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_init;
    logic     div_step;
    logic     inv_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

// ===== design/pfcm_ctrl.sv =====
// Controller state machine of the PFC current reference multiplier core.
// Sequences the shared multiplier and the divider; owns the handshakes.
// Depends on pfcm_pkg.
module pfcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  output logic                out_valid,
  input  logic                out_stall,
  output pfcm_pkg::dp_cmd_t    cmd,
  input  pfcm_pkg::dp_status_t status
);
  import pfcm_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = MUL_CUR_ERR;
    in_stall    = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = kind ? S_SQUARE : S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CUR_ERR;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SCALED_INV;
        state_next  = S_SAT;
      end
      S_SAT: begin
        // The result waits here until the output register is free.
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SQUARE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VOLT_SQ;
        state_next  = S_PREP;
      end
      S_PREP: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.inv_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled item");

  a_tick_goes_square: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && kind) |=> (state == S_SQUARE))
    else $error("tick item did not start the square");

  a_out_from_sat: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_SAT))
    else $error("output raised outside the saturation step");

endmodule

// ===== design/pfcm_dp.sv =====
// Datapath of the PFC current reference multiplier core: configuration
// registers, shared 16x16 multiplier, restoring divider and output register.
// Depends on pfcm_pkg.
module pfcm_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_enable,
  input  pfcm_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 kind,
  input  logic [15:0]          line_current,
  input  logic [15:0]          voltage_error,
  input  logic [15:0]          avg_voltage_sample,
  input  logic                 avg_voltage_ready,
  input  pfcm_pkg::dp_cmd_t     cmd,
  output pfcm_pkg::dp_status_t  status,
  output logic [15:0]          reference_code
);
  import pfcm_pkg::*;

  logic        run_enable;
  logic [15:0] dac_limit;
  logic [18:0] square_floor;
  logic [31:0] inverse_numerator;

  logic [15:0] avg_voltage;
  logic [15:0] inverse_square;
  logic [15:0] cur;
  logic [15:0] err;
  logic [31:0] prod;

  logic [19:0]       divisor;
  logic [19:0]       rem;
  logic [31:0]       quo;
  logic [CountW-1:0] count;

  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [18:0] square;
  logic [18:0] floored;
  logic [20:0] rem_shift;
  logic        rem_ge;
  logic [19:0] rem_next;
  logic [16:0] ref_full;
  logic [15:0] ref_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable        <= 1'b0;
      dac_limit         <= DacLimitReset;
      square_floor      <= SquareFloorReset;
      inverse_numerator <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_RUN_ENABLE:    run_enable        <= cfg_data[0];
        CFG_DAC_LIMIT:     dac_limit         <= cfg_data[15:0];
        CFG_SQUARE_FLOOR:  square_floor      <= cfg_data[18:0];
        CFG_INV_NUMERATOR: inverse_numerator <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_voltage    <= '0;
      inverse_square <= '0;
    end else begin
      if (cmd.capture && kind && avg_voltage_ready) begin
        avg_voltage <= avg_voltage_sample;
      end
      if (cmd.inv_load) begin
        inverse_square <= quo[15:0];
      end
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_CUR_ERR: begin
        mul_a = cur;
        mul_b = err;
      end
      MUL_SCALED_INV: begin
        // Keep only 16 bits of the scaled current-error product.
        mul_a = prod[ProdShift+15:ProdShift];
        mul_b = inverse_square;
      end
      MUL_VOLT_SQ: begin
        mul_a = avg_voltage;
        mul_b = avg_voltage;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= line_current;
      err <= voltage_error;
    end
    if (cmd.mul_en) begin
      prod <= 32'(mul_a) * 32'(mul_b);
    end
  end

  assign square  = prod[31:ProdShift];
  assign floored = (square < square_floor) ? square_floor : square;

  // One quotient bit per cycle; the remainder always stays below the divisor.
  assign rem_shift = {rem, quo[31]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});
  assign rem_next  = rem_ge ? 20'(rem_shift - {1'b0, divisor}) : rem_shift[19:0];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      divisor <= {1'b0, floored} + 20'd1;
      rem     <= '0;
      quo     <= inverse_numerator;
      count   <= '0;
    end else if (cmd.div_step) begin
      rem   <= rem_next;
      quo   <= {quo[30:0], rem_ge};
      count <= count + CountW'(1);
    end
  end

  assign status.div_last = (count == CountW'(DivSteps - 1));

  assign ref_full = prod[31:RefShift];
  assign ref_sat  = (ref_full > {1'b0, dac_limit}) ? dac_limit : ref_full[15:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      reference_code <= run_enable ? ref_sat : 16'd0;
    end
  end

  a_inv_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.inv_load |-> $past(cmd.div_step && status.div_last))
    else $error("inverse stored before the division finished");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < divisor))
    else $error("divider remainder out of range");

  a_avg_latch: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture && kind && avg_voltage_ready) |=> (avg_voltage == $past(avg_voltage_sample)))
    else $error("average voltage not latched on a ready tick");

endmodule

// ===== design/pfc_current_reference_multiplier_core.sv =====
// Top level of the PFC current reference multiplier core.
// Joins the controller pfcm_ctrl and the datapath pfcm_dp; uses pfcm_pkg.
//
//   channel  direction  handshake              payload
//   in       to core    in_valid / in_stall    kind, line_current, voltage_error,
//                                              avg_voltage_sample, avg_voltage_ready
//   out      from core  out_valid / out_stall  reference_code
//   cfg      to core    cfg_write_enable       cfg_index, cfg_data
//
// A sample item offers its result after two passes through the shared multiplier,
// then saturation into the output register.
// A tick item occupies the core through the square and the 32-step restoring divider.
// One item is in work at a time; in_stall is high until the item is finished.
// A stalled result holds the next sample in its saturation step; ticks go on.
// Synchronous reset clears control state and loads the register reset values.
module pfc_current_reference_multiplier_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [15:0]         line_current,
  input  logic [15:0]         voltage_error,
  input  logic [15:0]         avg_voltage_sample,
  input  logic                avg_voltage_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         reference_code,
  input  logic                cfg_write_enable,
  input  pfcm_pkg::cfg_index_t cfg_index,
  input  logic [31:0]         cfg_data
);
  import pfcm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  pfcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  pfcm_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_write_enable   (cfg_write_enable),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .kind               (kind),
    .line_current       (line_current),
    .voltage_error      (voltage_error),
    .avg_voltage_sample (avg_voltage_sample),
    .avg_voltage_ready  (avg_voltage_ready),
    .cmd                (cmd),
    .status             (status),
    .reference_code     (reference_code)
  );

endmodule

// ===== tb/pfcm_reference_checker.sv =====
`timescale 1ns / 100ps
// Checker for the PFC current reference multiplier core: watches the config,
// input and output channels, predicts each reference code and compares it.
// Depends on pfcm_pkg for the register codes, shifts and reset values.
module pfcm_reference_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 kind,
  input  logic [15:0]          line_current,
  input  logic [15:0]          voltage_error,
  input  logic [15:0]          avg_voltage_sample,
  input  logic                 avg_voltage_ready,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [15:0]          reference_code,
  input  logic                 cfg_write_enable,
  input  pfcm_pkg::cfg_index_t cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   mismatches,
  output int                   pending
);
  import pfcm_pkg::*;

  logic        run_en;
  logic [15:0] dac_lim;
  logic [18:0] sq_floor;
  logic [31:0] inv_num;
  logic [15:0] held_voltage;
  logic [15:0] inverse;
  logic [15:0] expected_refs[$];
  logic [15:0] oldest;

  function automatic logic [15:0] predict_inverse(input logic [15:0] volts);
    logic [31:0] square;
    logic [31:0] quotient;
    square = (32'(volts) * 32'(volts)) >> ProdShift;
    if (square < 32'(sq_floor)) square = 32'(sq_floor);
    quotient = inv_num / (square + 32'd1);
    return quotient[15:0];
  endfunction

  function automatic logic [15:0] predict_reference(input logic [15:0] cur,
                                                    input logic [15:0] err);
    logic [31:0] product;
    logic [15:0] scaled;
    logic [31:0] ref_val;
    if (!run_en) return 16'd0;
    product = 32'(cur) * 32'(err);
    // Only the low 16 bits of the scaled product feed the second multiply.
    scaled  = product[ProdShift +: 16];
    ref_val = (32'(scaled) * 32'(inverse)) >> RefShift;
    if (ref_val > 32'(dac_lim)) ref_val = 32'(dac_lim);
    return ref_val[15:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s: reference_code %0d, predicted %0d", $time, what, got, want);
    mismatches <= mismatches + 1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      run_en       = 1'b0;
      dac_lim      = DacLimitReset;
      sq_floor     = SquareFloorReset;
      inv_num      = 32'd0;
      held_voltage = 16'd0;
      inverse      = 16'd0;
      expected_refs.delete();
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_RUN_ENABLE:    run_en   = cfg_data[0];
          CFG_DAC_LIMIT:     dac_lim  = cfg_data[15:0];
          CFG_SQUARE_FLOOR:  sq_floor = cfg_data[18:0];
          CFG_INV_NUMERATOR: inv_num  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_refs.size() == 0) begin
          report_mismatch("result with no sample waiting", reference_code, 16'd0);
        end else begin
          oldest = expected_refs.pop_front();
          if (reference_code !== oldest)
            report_mismatch("wrong result", reference_code, oldest);
        end
      end
      if (in_valid && !in_stall) begin
        if (kind) begin
          // A tick recomputes the inverse even when no fresh voltage comes.
          if (avg_voltage_ready) held_voltage = avg_voltage_sample;
          inverse = predict_inverse(held_voltage);
        end else begin
          expected_refs.push_back(predict_reference(line_current, voltage_error));
        end
      end
      pending <= expected_refs.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for pfc_current_reference_multiplier_core: drives reset, the
// config port and bursty items, stalls the output, and gives the verdict.
// Depends on pfcm_pkg and on the checker pfcm_reference_checker.
module tb;
  import pfcm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [15:0] line_current = 16'd0;
  logic [15:0] voltage_error = 16'd0;
  logic [15:0] avg_voltage_sample = 16'd0;
  logic        avg_voltage_ready = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] reference_code;
  logic        cfg_write_enable = 1'b0;
  cfg_index_t  cfg_index = CFG_RUN_ENABLE;
  logic [31:0] cfg_data = 32'd0;

  int mismatches;
  int pending;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  pfc_current_reference_multiplier_core uut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .kind               (kind),
    .line_current       (line_current),
    .voltage_error      (voltage_error),
    .avg_voltage_sample (avg_voltage_sample),
    .avg_voltage_ready  (avg_voltage_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .reference_code     (reference_code),
    .cfg_write_enable   (cfg_write_enable),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  pfcm_reference_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .kind               (kind),
    .line_current       (line_current),
    .voltage_error      (voltage_error),
    .avg_voltage_sample (avg_voltage_sample),
    .avg_voltage_ready  (avg_voltage_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .reference_code     (reference_code),
    .cfg_write_enable   (cfg_write_enable),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver alternates between free running, random stalls and solid stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(1, 30);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= 1'b1;
    endcase
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [15:0] rand16();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Ends an item with either the next item of the burst or a random gap.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_item(input logic k, input logic [15:0] cur, input logic [15:0] err,
                           input logic [15:0] volts, input logic rdy);
    in_valid           <= 1'b1;
    kind               <= k;
    line_current       <= cur;
    voltage_error      <= err;
    avg_voltage_sample <= volts;
    avg_voltage_ready  <= rdy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pace();
  endtask

  // Waits for every predicted result, then for longer than a tick takes.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= value;
    @(posedge clk);
  endtask

  task automatic set_config(input logic run, input logic [15:0] lim,
                            input logic [18:0] flr, input logic [31:0] num);
    write_reg(CFG_RUN_ENABLE, 32'(run));
    write_reg(CFG_DAC_LIMIT, 32'(lim));
    write_reg(CFG_SQUARE_FLOOR, 32'(flr));
    write_reg(CFG_INV_NUMERATOR, num);
    cfg_write_enable <= 1'b0;
  endtask

  initial begin
    logic        run;
    logic [15:0] lim;
    logic [18:0] flr;
    logic [31:0] num;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset the converter is stopped and the inverse is zero.
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    send_item(1'b1, 16'd0, 16'd0, 16'h1234, 1'b0);
    send_item(1'b0, 16'h8000, 16'h4000, 16'd0, 1'b0);
    drain_results();

    // No floor and the largest numerator: the quotient overflows 16 bits.
    set_config(1'b1, 16'hFFFF, 19'd0, 32'hFFFF_FFFF);
    send_item(1'b1, 16'd0, 16'd0, 16'd0, 1'b1);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    send_item(1'b0, 16'd0, 16'd0, 16'hFFFF, 1'b1);
    send_item(1'b0, 16'hFFFF, 16'd0, 16'd0, 1'b0);
    send_item(1'b0, 16'd0, 16'hFFFF, 16'd0, 1'b0);
    send_item(1'b0, 16'h2000, 16'd1, 16'd0, 1'b0);
    send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    send_item(1'b0, 16'h1234, 16'h5678, 16'd0, 1'b0);
    // A tick without a fresh voltage keeps the held one.
    send_item(1'b1, 16'd0, 16'd0, 16'h0001, 1'b0);
    send_item(1'b0, 16'hFFFF, 16'h8000, 16'd0, 1'b0);
    drain_results();

    // A zero DAC limit saturates everything; the largest floor wins the division.
    set_config(1'b1, 16'd0, 19'h7FFFF, 32'h1234_5678);
    send_item(1'b1, 16'd0, 16'd0, 16'h0100, 1'b1);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    send_item(1'b0, 16'd0, 16'd0, 16'd0, 1'b0);
    drain_results();

    // Ticks still update the inverse while the converter is stopped.
    set_config(1'b0, 16'd4095, 19'd1, 32'hFFFF_FFFF);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    send_item(1'b1, 16'd0, 16'd0, 16'h0200, 1'b1);
    send_item(1'b0, 16'h4000, 16'h4000, 16'd0, 1'b0);
    drain_results();
    set_config(1'b1, 16'd4095, 19'd1, 32'hFFFF_FFFF);
    send_item(1'b0, 16'h4000, 16'h4000, 16'd0, 1'b0);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      drain_results();
      if (phase == 0) begin
        run = 1'b1;
        lim = 16'hFFFF;
        flr = 19'd0;
        num = 32'hFFFF_FFFF;
      end else begin
        run = (phase == 1) ? 1'b0 : 1'($urandom_range(0, 5) != 0);
        case ($urandom_range(0, 4))
          0:       lim = 16'd0;
          1:       lim = 16'hFFFF;
          2:       lim = 16'd4095;
          3:       lim = 16'($urandom_range(0, 4095));
          default: lim = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0:       flr = 19'd0;
          1:       flr = 19'h7FFFF;
          2:       flr = 19'd1;
          3:       flr = 19'($urandom_range(0, 2000));
          default: flr = 19'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0:       num = 32'hFFFF_FFFF;
          1:       num = 32'd0;
          2:       num = $urandom >> $urandom_range(0, 12);
          default: num = $urandom;
        endcase
      end
      set_config(run, lim, flr, num);
      // Start each phase with a fresh voltage so the inverse follows the new setting.
      send_item(1'b1, rand16(), rand16(), rand16(), 1'b1);
      for (int n = 0; n < 56; n++) begin
        if ($urandom_range(0, 3) == 0)
          send_item(1'b1, 16'($urandom), 16'($urandom), rand16(),
                    1'($urandom_range(0, 1)));
        else
          send_item(1'b0, rand16(), rand16(), 16'($urandom), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    drain_results();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
